// ===== rtl/pmcf_pkg.sv =====
// Shared types, codes and the sequencer program ROM for the command framer.
`timescale 1ns / 1ps

package pmcf_pkg;

    // Command kinds
    localparam logic [2:0] KIND_STATUS   = 3'd0;
    localparam logic [2:0] KIND_START    = 3'd1;
    localparam logic [2:0] KIND_SHUTDOWN = 3'd2;
    localparam logic [2:0] KIND_SET_VI   = 3'd3;
    localparam logic [2:0] KIND_LIMIT    = 3'd4;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] PROG_LEN = 5'd24;

    // Program entry points
    localparam logic [STEP_W-1:0] ENTRY_STATUS   = 5'd4;
    localparam logic [STEP_W-1:0] ENTRY_START    = 5'd7;
    localparam logic [STEP_W-1:0] ENTRY_SHUTDOWN = 5'd11;
    localparam logic [STEP_W-1:0] ENTRY_SET      = 5'd15;
    localparam logic [STEP_W-1:0] ENTRY_CRC      = 5'd22;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [2:0] {
        SRC_CONST,
        SRC_VH,
        SRC_VL,
        SRC_IH,
        SRC_IL,
        SRC_CRCH,
        SRC_CRCL
    } src_t;

    typedef enum logic [1:0] {
        FLOW_NEXT,
        FLOW_DISPATCH,
        FLOW_GOTO,
        FLOW_END
    } flow_t;

    typedef struct packed {
        src_t              src;
        logic [7:0]        data;
        logic              crc_upd;
        logic              last;
        flow_t             flow;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    // Build one control word
    function automatic ctrl_word_t cw(src_t src, logic [7:0] data, logic crc_upd,
                                      logic last, flow_t flow, logic [STEP_W-1:0] target);
        ctrl_word_t w;
        w.src     = src;
        w.data    = data;
        w.crc_upd = crc_upd;
        w.last    = last;
        w.flow    = flow;
        w.target  = target;
        return w;
    endfunction

    // Program ROM: preamble, per-kind body, shared CRC tail
    function automatic ctrl_word_t prog_rom(logic [STEP_W-1:0] addr);
        ctrl_word_t w;
        unique case (addr)
            5'd0:    w = cw(SRC_CONST, 8'hA0, 1'b0, 1'b0, FLOW_NEXT, 5'd0);
            5'd1:    w = cw(SRC_CONST, 8'hA0, 1'b0, 1'b0, FLOW_NEXT, 5'd0);
            5'd2:    w = cw(SRC_CONST, 8'hA0, 1'b0, 1'b0, FLOW_NEXT, 5'd0);
            5'd3:    w = cw(SRC_CONST, 8'hFF, 1'b0, 1'b0, FLOW_DISPATCH, 5'd0);
            // status request
            5'd4:    w = cw(SRC_CONST, 8'h04, 1'b1, 1'b0, FLOW_NEXT, 5'd0);
            5'd5:    w = cw(SRC_CONST, 8'h00, 1'b1, 1'b0, FLOW_NEXT, 5'd0);
            5'd6:    w = cw(SRC_CONST, 8'h00, 1'b1, 1'b0, FLOW_GOTO, ENTRY_CRC);
            // start
            5'd7:    w = cw(SRC_CONST, 8'h05, 1'b1, 1'b0, FLOW_NEXT, 5'd0);
            5'd8:    w = cw(SRC_CONST, 8'h00, 1'b1, 1'b0, FLOW_NEXT, 5'd0);
            5'd9:    w = cw(SRC_CONST, 8'h02, 1'b1, 1'b0, FLOW_NEXT, 5'd0);
            5'd10:   w = cw(SRC_CONST, 8'h88, 1'b1, 1'b0, FLOW_GOTO, ENTRY_CRC);
            // shutdown
            5'd11:   w = cw(SRC_CONST, 8'h05, 1'b1, 1'b0, FLOW_NEXT, 5'd0);
            5'd12:   w = cw(SRC_CONST, 8'h00, 1'b1, 1'b0, FLOW_NEXT, 5'd0);
            5'd13:   w = cw(SRC_CONST, 8'h02, 1'b1, 1'b0, FLOW_NEXT, 5'd0);
            5'd14:   w = cw(SRC_CONST, 8'h00, 1'b1, 1'b0, FLOW_GOTO, ENTRY_CRC);
            // set voltage and current, set current limit
            5'd15:   w = cw(SRC_CONST, 8'h08, 1'b1, 1'b0, FLOW_NEXT, 5'd0);
            5'd16:   w = cw(SRC_CONST, 8'h00, 1'b1, 1'b0, FLOW_NEXT, 5'd0);
            5'd17:   w = cw(SRC_CONST, 8'h10, 1'b1, 1'b0, FLOW_NEXT, 5'd0);
            5'd18:   w = cw(SRC_VH,    8'h00, 1'b1, 1'b0, FLOW_NEXT, 5'd0);
            5'd19:   w = cw(SRC_VL,    8'h00, 1'b1, 1'b0, FLOW_NEXT, 5'd0);
            5'd20:   w = cw(SRC_IH,    8'h00, 1'b1, 1'b0, FLOW_NEXT, 5'd0);
            5'd21:   w = cw(SRC_IL,    8'h00, 1'b1, 1'b0, FLOW_NEXT, 5'd0);
            // CRC tail
            5'd22:   w = cw(SRC_CRCH,  8'h00, 1'b0, 1'b0, FLOW_NEXT, 5'd0);
            5'd23:   w = cw(SRC_CRCL,  8'h00, 1'b0, 1'b1, FLOW_END, 5'd0);
            default: w = cw(SRC_CONST, 8'h00, 1'b0, 1'b1, FLOW_END, 5'd0);
        endcase
        return w;
    endfunction

    // CRC-16/XMODEM update by one byte, MSB first
    function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/power_module_command_framer_unit.sv =====
// Top level of the power module command framer: microcoded byte sequencer.
`timescale 1ns / 1ps

// Takes one command beat and emits its frame (A0 A0 A0 FF, length, 00, command
// bytes, CRC-16/XMODEM high then low) one byte beat per cycle while out_ready
// stays high, last_byte set on the CRC low byte. A step counter walks a 24-word
// program ROM; each step puts one byte into the output register, so a frame holds
// N bytes (9, 10 or 13), and the next command is taken in the cycle after the last
// byte is loaded. Kinds 5 to 7 are taken and produce no bytes. max_voltage_code
// is written with cfg_wr_en and used in place of voltage_code by the current
// limit command.
module power_module_command_framer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [15:0] voltage_code,
    input  logic [15:0] current_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_byte,
    output logic        last_byte
);

    logic [15:0]                  max_voltage_code_reg;
    logic                         busy_reg;
    logic [pmcf_pkg::STEP_W-1:0]  step_reg;
    logic [pmcf_pkg::STEP_W-1:0]  step_next;
    logic [2:0]                   kind_reg;
    logic [15:0]                  volt_reg;
    logic [15:0]                  curr_reg;
    logic [15:0]                  crc_reg;
    logic                         out_valid_reg;
    logic [7:0]                   frame_byte_reg;
    logic                         last_byte_reg;
    pmcf_pkg::ctrl_word_t         word;
    logic [7:0]                   byte_sel;
    logic                         in_fire;
    logic                         load;
    logic                         kind_ok;

    assign in_ready   = !busy_reg;
    assign in_fire    = in_valid && in_ready;
    assign load       = busy_reg && (!out_valid_reg || out_ready);
    assign kind_ok    = (kind <= pmcf_pkg::KIND_LIMIT);
    assign word       = pmcf_pkg::prog_rom(step_reg);
    assign out_valid  = out_valid_reg;
    assign frame_byte = frame_byte_reg;
    assign last_byte  = last_byte_reg;

    // Select the byte for the current step
    always_comb
    begin
        case (word.src)
            pmcf_pkg::SRC_VH:   byte_sel = volt_reg[15:8];
            pmcf_pkg::SRC_VL:   byte_sel = volt_reg[7:0];
            pmcf_pkg::SRC_IH:   byte_sel = curr_reg[15:8];
            pmcf_pkg::SRC_IL:   byte_sel = curr_reg[7:0];
            pmcf_pkg::SRC_CRCH: byte_sel = crc_reg[15:8];
            pmcf_pkg::SRC_CRCL: byte_sel = crc_reg[7:0];
            default:            byte_sel = word.data;
        endcase
    end

    // Sequence the next step: advance, jump by kind, or jump to the tail
    always_comb
    begin
        step_next = step_reg + 1'b1;
        case (word.flow)
            pmcf_pkg::FLOW_DISPATCH:
            begin
                case (kind_reg) inside
                    pmcf_pkg::KIND_STATUS:   step_next = pmcf_pkg::ENTRY_STATUS;
                    pmcf_pkg::KIND_START:    step_next = pmcf_pkg::ENTRY_START;
                    pmcf_pkg::KIND_SHUTDOWN: step_next = pmcf_pkg::ENTRY_SHUTDOWN;
                    pmcf_pkg::KIND_SET_VI, pmcf_pkg::KIND_LIMIT:
                                             step_next = pmcf_pkg::ENTRY_SET;
                    default:                 step_next = pmcf_pkg::ENTRY_CRC;
                endcase
            end
            pmcf_pkg::FLOW_GOTO: step_next = word.target;
            default:             step_next = step_reg + 1'b1;
        endcase
    end

    // Hold the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_voltage_code_reg <= 16'd0;
        else if (cfg_wr_en)
            max_voltage_code_reg <= cfg_wr_data;
    end

    // Control: busy flag, step counter, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                busy_reg <= kind_ok;
                step_reg <= '0;
            end
            else if (load)
            begin
                step_reg <= step_next;
                if (word.flow == pmcf_pkg::FLOW_END)
                    busy_reg <= 1'b0;
            end

            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath: latch the command, run the CRC, load the output beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg <= kind;
            volt_reg <= (kind == pmcf_pkg::KIND_LIMIT) ? max_voltage_code_reg : voltage_code;
            curr_reg <= current_code;
            crc_reg  <= 16'd0;
        end
        else if (load && word.crc_upd)
            crc_reg <= pmcf_pkg::crc_byte(crc_reg, byte_sel);

        if (load)
        begin
            frame_byte_reg <= byte_sel;
            last_byte_reg  <= word.last;
        end
    end

    // Loading the closing byte frees the input side
    a_end_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        load && word.last |=> in_ready)
        else $error("input not ready after closing byte");

    // A valid command starts the program at step zero
    a_start_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && kind_ok |=> busy_reg && step_reg == '0)
        else $error("command did not start the program");

    // The step counter stays inside the program while busy
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg < pmcf_pkg::PROG_LEN)
        else $error("step counter left the program");

endmodule
